// File: src/tcon_pkg.sv
// tcon_pkg: shared types, codes and reset values for the typewriter text console
// used by tcon_regs, tcon_engine, tcon_outq and the top level; no dependencies
`default_nettype none

package tcon_pkg;

  // parameter defaults
  localparam int TEXT_DEPTH_DEF  = 256;
  localparam int ROW_TILES_DEF   = 20;
  localparam int TICK_PERIOD_DEF = 4;

  // configuration register reset values
  localparam logic [4:0] FIRST_ROW_RST   = 5'd8;
  localparam logic [4:0] LINE_COUNT_RST  = 5'd7;
  localparam logic [7:0] FONT_OFFSET_RST = 8'd32;
  localparam logic [7:0] CURSOR_CHAR_RST = 8'd129;

  // configuration register indexes
  localparam logic [1:0] REG_FIRST_ROW   = 2'd0;
  localparam logic [1:0] REG_LINE_COUNT  = 2'd1;
  localparam logic [1:0] REG_FONT_OFFSET = 2'd2;
  localparam logic [1:0] REG_CURSOR_CHAR = 2'd3;

  // input command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // character codes
  localparam logic [7:0] CHAR_END     = 8'd0;
  localparam logic [7:0] CHAR_BELL    = 8'd7;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;

  // blink countdown
  localparam logic [3:0] BLINK_START = 4'd8;
  localparam logic [3:0] BLINK_ON_A  = 4'd8;
  localparam logic [3:0] BLINK_ON_B  = 4'd4;

  // result kinds
  typedef enum logic [1:0] {
    KIND_TILE = 2'd0,
    KIND_COPY = 2'd1,
    KIND_FILL = 2'd2
  } kind_t;

  // scroll sequencer
  typedef enum logic [2:0] {
    SCR_IDLE    = 3'd0,
    SCR_COPY_LO = 3'd1,
    SCR_COPY_HI = 3'd2,
    SCR_FILL    = 3'd3,
    SCR_DONE    = 3'd4
  } scroll_t;

  // configuration registers as seen by the engine
  typedef struct packed {
    logic [4:0] first_row;
    logic [4:0] line_count;
    logic [7:0] font_offset;
    logic [7:0] cursor_char;
  } cfg_t;

  // one result item
  typedef struct packed {
    kind_t      kind;
    logic [4:0] col;
    logic [4:0] row;
    logic [7:0] tile;
    logic [4:0] src_row;
    logic [5:0] span;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

// File: src/tcon_ram.sv
// tcon_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module tcon_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/tcon_regs.sv
// tcon_regs: configuration register file behind the APB-style port
// depends on tcon_pkg
`default_nettype none

module tcon_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output tcon_pkg::cfg_t   cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_row   <= tcon_pkg::FIRST_ROW_RST;
      cfg.line_count  <= tcon_pkg::LINE_COUNT_RST;
      cfg.font_offset <= tcon_pkg::FONT_OFFSET_RST;
      cfg.cursor_char <= tcon_pkg::CURSOR_CHAR_RST;
    end else if (wr) begin
      unique case (idx)
        tcon_pkg::REG_FIRST_ROW:   cfg.first_row   <= pwdata[4:0];
        tcon_pkg::REG_LINE_COUNT:  cfg.line_count  <= pwdata[4:0];
        tcon_pkg::REG_FONT_OFFSET: cfg.font_offset <= pwdata[7:0];
        tcon_pkg::REG_CURSOR_CHAR: cfg.cursor_char <= pwdata[7:0];
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      tcon_pkg::REG_FIRST_ROW:   prdata = {27'd0, cfg.first_row};
      tcon_pkg::REG_LINE_COUNT:  prdata = {27'd0, cfg.line_count};
      tcon_pkg::REG_FONT_OFFSET: prdata = {24'd0, cfg.font_offset};
      tcon_pkg::REG_CURSOR_CHAR: prdata = {24'd0, cfg.cursor_char};
    endcase
  end

endmodule

`default_nettype wire

// File: src/tcon_text.sv
// tcon_text: text store with the current and lookahead bytes kept ready for the engine
// depends on tcon_ram
`default_nettype none

module tcon_text #(
  parameter int TEXT_DEPTH = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          we,
  input  wire logic [$clog2(TEXT_DEPTH)-1:0] waddr,
  input  wire logic [7:0]                    wdata,
  input  wire logic                          tick,
  input  wire logic [$clog2(TEXT_DEPTH)-1:0] rp,
  input  wire logic [$clog2(TEXT_DEPTH)-1:0] rp_next,
  output logic      [7:0]                    cur_byte,
  output logic      [7:0]                    nxt_byte
);

  localparam int AW = $clog2(TEXT_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TEXT_DEPTH - 1);

  logic [AW-1:0] la;
  logic [AW-1:0] la_next;
  logic [7:0]    cur_q;
  logic [7:0]    nxt_q;
  logic [7:0]    cur_hold;
  logic [7:0]    nxt_hold;
  logic          fresh;

  // lookahead addresses wrap at the store depth
  assign la      = (rp == LAST_ADDR) ? '0 : rp + 1'b1;
  assign la_next = (rp_next == LAST_ADDR) ? '0 : rp_next + 1'b1;

  // one copy of the store per read address
  tcon_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_ram_cur (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rp_next),
    .rdata (cur_q)
  );

  tcon_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_ram_nxt (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (la_next),
    .rdata (nxt_q)
  );

  // right after a tick the ram output is current, otherwise the held copy
  assign cur_byte = fresh ? cur_q : cur_hold;
  assign nxt_byte = fresh ? nxt_q : nxt_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh <= 1'b0;
    end else begin
      fresh <= tick;
    end
  end

  // held copies follow loads that hit the read addresses
  always_ff @(posedge clk) begin
    cur_hold <= (we && waddr == rp) ? wdata : cur_byte;
    nxt_hold <= (we && waddr == la) ? wdata : nxt_byte;
  end

endmodule

`default_nettype wire

// File: src/tcon_engine.sv
// tcon_engine: cursor, blink, scroll and phase state with the per-item result logic
// depends on tcon_pkg
`default_nettype none

module tcon_engine #(
  parameter int TEXT_DEPTH  = 256,
  parameter int ROW_TILES   = 20,
  parameter int TICK_PERIOD = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tcon_pkg::cfg_t                cfg,
  input  wire logic                          go,
  input  wire logic                          in_cmd,
  input  wire logic [7:0]                    cur_byte,
  input  wire logic [7:0]                    nxt_byte,
  output logic      [$clog2(TEXT_DEPTH)-1:0] rp,
  output logic      [$clog2(TEXT_DEPTH)-1:0] rp_next,
  output tcon_pkg::res_t                     res0,
  output logic                               res0_valid,
  output tcon_pkg::res_t                     res1,
  output logic                               res1_valid
);

  localparam int AW = $clog2(TEXT_DEPTH);
  localparam int PW = $clog2(TICK_PERIOD);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(TEXT_DEPTH - 1);
  localparam logic [PW-1:0] LAST_PHASE = PW'(TICK_PERIOD - 1);
  localparam logic [5:0]    COL_LIMIT  = 6'(ROW_TILES - 1);
  localparam logic [5:0]    FILL_SPAN  = 6'(ROW_TILES);

  logic [4:0]        ccol, ccol_next;
  logic [4:0]        crow, crow_next;
  logic [PW-1:0]     phase, phase_next;
  logic [3:0]        blink, blink_next;
  tcon_pkg::scroll_t scroll, scroll_next;

  logic          is_tick;
  logic          p0;
  logic [7:0]    space_tile;
  logic [7:0]    caret_tile;
  logic [4:0]    row_p1;
  logic [4:0]    area_end;
  logic [4:0]    lm1;
  logic [4:0]    half;
  logic [AW-1:0] rp_inc;

  // decode shared by next state and results
  assign is_tick     = (in_cmd == tcon_pkg::CMD_TICK);
  assign p0          = (phase == '0);
  assign space_tile  = tcon_pkg::CHAR_SPACE - cfg.font_offset;
  assign caret_tile  = cfg.cursor_char - cfg.font_offset;
  assign row_p1      = crow + 5'd1;
  assign area_end    = cfg.first_row + cfg.line_count;
  assign lm1         = cfg.line_count - 5'd1;
  assign half        = {1'b0, lm1[4:1]};
  assign rp_inc      = (rp == LAST_ADDR) ? '0 : rp + 1'b1;

  // next state
  always_comb begin
    rp_next     = rp;
    ccol_next   = ccol;
    crow_next   = crow;
    phase_next  = phase;
    blink_next  = blink;
    scroll_next = scroll;
    if (go && is_tick) begin
      phase_next = (phase == LAST_PHASE) ? '0 : phase + 1'b1;
      if (p0) begin
        if (blink != 4'd0) begin
          blink_next = blink - 4'd1;
        end else if (cur_byte == tcon_pkg::CHAR_NEWLINE) begin
          ccol_next = 5'd0;
          rp_next   = rp_inc;
          if (row_p1 == area_end) begin
            crow_next   = area_end - 5'd1;
            scroll_next = tcon_pkg::SCR_COPY_LO;
          end else begin
            crow_next = row_p1;
          end
        end else if (cur_byte == tcon_pkg::CHAR_END) begin
          // restart from the first character
          rp_next     = '0;
          ccol_next   = 5'd0;
          crow_next   = cfg.first_row;
          blink_next  = 4'd0;
          scroll_next = tcon_pkg::SCR_IDLE;
        end else if (cur_byte == tcon_pkg::CHAR_BELL) begin
          blink_next = tcon_pkg::BLINK_START;
          rp_next    = rp_inc;
        end else begin
          ccol_next = ccol + 5'd1;
          rp_next   = rp_inc;
        end
      end else begin
        unique case (scroll)
          tcon_pkg::SCR_COPY_LO: scroll_next = tcon_pkg::SCR_COPY_HI;
          tcon_pkg::SCR_COPY_HI: scroll_next = tcon_pkg::SCR_FILL;
          tcon_pkg::SCR_FILL:    scroll_next = tcon_pkg::SCR_DONE;
          default:               scroll_next = scroll;
        endcase
      end
    end
  end

  // results of the item at hand
  always_comb begin
    res0.kind    = tcon_pkg::KIND_TILE;
    res0.col     = ccol;
    res0.row     = crow;
    res0.tile    = space_tile;
    res0.src_row = 5'd0;
    res0.span    = 6'd0;
    res1.kind    = tcon_pkg::KIND_TILE;
    res1.col     = ccol + 5'd1;
    res1.row     = crow;
    res1.tile    = caret_tile;
    res1.src_row = 5'd0;
    res1.span    = 6'd0;
    res1.last    = 1'b1;
    res0_valid   = 1'b0;
    res1_valid   = 1'b0;
    if (is_tick) begin
      if (p0) begin
        if (blink != 4'd0) begin
          // blink writes on even counts only
          res0_valid = !blink[0];
          res0.tile  = (blink == tcon_pkg::BLINK_ON_A || blink == tcon_pkg::BLINK_ON_B) ?
                       caret_tile : space_tile;
        end else if (cur_byte == tcon_pkg::CHAR_NEWLINE) begin
          res0_valid = 1'b1;
        end else if (cur_byte != tcon_pkg::CHAR_END && cur_byte != tcon_pkg::CHAR_BELL) begin
          res0_valid = 1'b1;
          res0.tile  = cur_byte - cfg.font_offset;
          res1_valid = (nxt_byte != tcon_pkg::CHAR_BELL) && ({1'b0, ccol} < COL_LIMIT);
        end
      end else begin
        unique case (scroll)
          tcon_pkg::SCR_COPY_LO: begin
            res0_valid   = 1'b1;
            res0.kind    = tcon_pkg::KIND_COPY;
            res0.col     = 5'd0;
            res0.row     = cfg.first_row;
            res0.tile    = 8'd0;
            res0.src_row = cfg.first_row + 5'd1;
            res0.span    = {1'b0, half};
          end
          tcon_pkg::SCR_COPY_HI: begin
            res0_valid   = 1'b1;
            res0.kind    = tcon_pkg::KIND_COPY;
            res0.col     = 5'd0;
            res0.row     = cfg.first_row + half;
            res0.tile    = 8'd0;
            res0.src_row = cfg.first_row + half + 5'd1;
            res0.span    = {1'b0, lm1 - half};
          end
          tcon_pkg::SCR_FILL: begin
            res0_valid   = 1'b1;
            res0.kind    = tcon_pkg::KIND_FILL;
            res0.col     = 5'd0;
            res0.row     = cfg.first_row + lm1;
            res0.span    = FILL_SPAN;
          end
          default: res0_valid = 1'b0;
        endcase
      end
    end
    res0.last = !res1_valid;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rp     <= '0;
      ccol   <= 5'd0;
      crow   <= tcon_pkg::FIRST_ROW_RST;
      phase  <= '0;
      blink  <= 4'd0;
      scroll <= tcon_pkg::SCR_IDLE;
    end else begin
      rp     <= rp_next;
      ccol   <= ccol_next;
      crow   <= crow_next;
      phase  <= phase_next;
      blink  <= blink_next;
      scroll <= scroll_next;
    end
  end

  // checks
  a_blink_range: assert property (@(posedge clk) disable iff (rst)
    blink <= tcon_pkg::BLINK_START)
    else $error("blink countdown out of range");

  a_blink_only_phase0: assert property (@(posedge clk) disable iff (rst)
    go && is_tick && !p0 |=> blink == $past(blink))
    else $error("blink countdown moved outside phase 0");

  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    res1_valid |-> res0_valid && is_tick && p0)
    else $error("second result without a first");

endmodule

`default_nettype wire

// File: src/tcon_outq.sv
// tcon_outq: two-slot result buffer that hands results to the output stream one at a time
// depends on tcon_pkg
`default_nettype none

module tcon_outq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tcon_pkg::res_t res0,
  input  wire logic           res1_valid,
  input  wire tcon_pkg::res_t res1,
  output logic                space,
  output logic                out_valid,
  input  wire logic           out_ready,
  output tcon_pkg::res_t      out_res
);

  tcon_pkg::res_t slot0, slot1;
  logic           v0, v1;
  logic           take;

  assign take      = v0 && out_ready;
  assign space     = !v0 || (!v1 && take);
  assign out_valid = v0;
  assign out_res   = slot0;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (push) begin
      v0 <= 1'b1;
      v1 <= res1_valid;
    end else if (take) begin
      v0 <= v1;
      v1 <= 1'b0;
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot0 <= res0;
      slot1 <= res1;
    end else if (take) begin
      slot0 <= slot1;
    end
  end

  // checks
  a_order: assert property (@(posedge clk) disable iff (rst)
    v1 |-> v0)
    else $error("second slot full with first slot empty");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> space)
    else $error("results pushed into a full buffer");

endmodule

`default_nettype wire

// File: src/typewriter_text_console.sv
// typewriter_text_console: top level of the tile map typewriter console
// depends on tcon_pkg, tcon_regs, tcon_text, tcon_engine, tcon_outq
`default_nettype none

// Streams text into a tile map as a typewriter would. Items on the slave stream
// either load one text byte (tuser low) or are one time tick (tuser high); the
// master stream carries tile writes, row copies and row fills, with tlast on the
// last result of a tick. An item is taken every clock cycle unless the output
// buffer has no room: it is registered, handled by the engine against the text
// store, and its zero, one or two results go into a two-slot output buffer. A tick
// that gives two tile writes fills both slots, so the next tick with results
// waits; loads and silent ticks never wait. The text store is a block RAM kept in
// two copies so that the current and the next character are both at hand; it is
// not cleared after reset, and ticks must not reach an entry never loaded.
// Configuration is written through the APB-style port while the stream is idle.
module typewriter_text_console #(
  parameter int TEXT_DEPTH  = tcon_pkg::TEXT_DEPTH_DEF,
  parameter int ROW_TILES   = tcon_pkg::ROW_TILES_DEF,
  parameter int TICK_PERIOD = tcon_pkg::TICK_PERIOD_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // slave stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // load_addr[7:0], load_byte[15:8]
  input  wire logic        s_tuser,   // cmd
  // master stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // col[4:0], row[9:5], tile[17:10], src_row[22:18],
                                      // span[28:23], zero[31:29]
  output logic      [1:0]  m_tuser,   // kind
  output logic             m_tlast,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int AW = $clog2(TEXT_DEPTH);

  tcon_pkg::cfg_t cfg;
  tcon_pkg::res_t res0, res1, out_res;
  logic           res0_valid, res1_valid;
  logic           space;
  logic           fire;

  logic          in_valid;
  logic          in_cmd;
  logic [7:0]    in_addr;
  logic [7:0]    in_byte;
  logic          in_range;
  logic          store_we;
  logic [AW-1:0] rp, rp_next;
  logic [7:0]    cur_byte, nxt_byte;

  // input register
  assign fire     = in_valid && (!res0_valid || space);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd  <= s_tuser;
      in_addr <= s_tdata[7:0];
      in_byte <= s_tdata[15:8];
    end
  end

  // loads beyond the store depth are dropped
  assign in_range = (32'(in_addr) < 32'(TEXT_DEPTH));
  assign store_we = fire && (in_cmd == tcon_pkg::CMD_LOAD) && in_range;

  tcon_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcon_text #(.TEXT_DEPTH(TEXT_DEPTH)) u_text (
    .clk      (clk),
    .rst      (rst),
    .we       (store_we),
    .waddr    (AW'(in_addr)),
    .wdata    (in_byte),
    .tick     (fire && (in_cmd == tcon_pkg::CMD_TICK)),
    .rp       (rp),
    .rp_next  (rp_next),
    .cur_byte (cur_byte),
    .nxt_byte (nxt_byte)
  );

  tcon_engine #(
    .TEXT_DEPTH  (TEXT_DEPTH),
    .ROW_TILES   (ROW_TILES),
    .TICK_PERIOD (TICK_PERIOD)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .go         (fire),
    .in_cmd     (in_cmd),
    .cur_byte   (cur_byte),
    .nxt_byte   (nxt_byte),
    .rp         (rp),
    .rp_next    (rp_next),
    .res0       (res0),
    .res0_valid (res0_valid),
    .res1       (res1),
    .res1_valid (res1_valid)
  );

  tcon_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (fire && res0_valid),
    .res0       (res0),
    .res1_valid (res1_valid),
    .res1       (res1),
    .space      (space),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (out_res)
  );

  // output packing
  assign m_tdata = {3'd0, out_res.span, out_res.src_row, out_res.tile, out_res.row, out_res.col};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

endmodule

`default_nettype wire

// File: test/tcon_checker.sv
`timescale 1ns / 100ps
// tcon_checker: scoreboard for the typewriter text console
// follows the text stream and the register port, predicts every tile map command
// and compares it with the master stream; depends on tcon_pkg only

module tcon_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [15:0] s_tdata,   // load_addr[7:0], load_byte[15:8]
  input  wire logic        s_tuser,   // cmd
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [31:0] m_tdata,   // col[4:0], row[9:5], tile[17:10], src_row[22:18],
                                      // span[28:23]
  input  wire logic [1:0]  m_tuser,   // kind
  input  wire logic        m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output int               fails,
  output int               ops_waiting
);
  import tcon_pkg::*;

  localparam int ROW_TILES = ROW_TILES_DEF;

  // own copy of the console state
  logic [7:0] text_mem [0:255];
  logic [7:0] rd_ptr;
  logic [4:0] cur_col;
  logic [4:0] cur_row;
  logic [1:0] phase;
  logic [3:0] blink;
  scroll_t    scroll;
  cfg_t       cfg;

  // tile map commands still to come out, oldest first
  res_t       ops_due [$];
  int         tick_ops;

  task automatic queue_op(input kind_t k, input logic [4:0] c, input logic [4:0] r,
                          input logic [7:0] t, input logic [4:0] sr, input logic [5:0] sp);
    res_t op;
    op.kind    = k;
    op.col     = c;
    op.row     = r;
    op.tile    = t;
    op.src_row = sr;
    op.span    = sp;
    op.last    = 1'b0;
    ops_due.push_back(op);
    tick_ops++;
  endtask

  task automatic home_cursor();
    rd_ptr  = '0;
    cur_col = '0;
    cur_row = cfg.first_row;
    blink   = '0;
    scroll  = SCR_IDLE;
  endtask

  // phase zero: blink countdown or one character from the store
  task automatic type_step();
    logic [7:0] space_tile;
    logic [7:0] caret_tile;
    logic [7:0] ch;
    logic [7:0] nxt;
    logic [7:0] nxt_addr;
    logic [4:0] area_end;
    space_tile  = CHAR_SPACE - cfg.font_offset;
    caret_tile  = cfg.cursor_char - cfg.font_offset;
    if (blink != 4'd0) begin
      // even counts draw, odd counts only wait
      if (!blink[0])
        queue_op(KIND_TILE, cur_col, cur_row,
                 (blink == BLINK_ON_A || blink == BLINK_ON_B) ? caret_tile : space_tile,
                 5'd0, 6'd0);
      blink = blink - 4'd1;
    end else begin
      ch = text_mem[rd_ptr];
      if (ch == CHAR_END) begin
        home_cursor();
      end else begin
        if (ch == CHAR_NEWLINE) begin
          area_end = cfg.first_row + cfg.line_count;
          queue_op(KIND_TILE, cur_col, cur_row, space_tile, 5'd0, 6'd0);
          cur_col = '0;
          cur_row = cur_row + 5'd1;
          // past the last line: stay on it and scroll
          if (cur_row == area_end) begin
            cur_row = area_end - 5'd1;
            scroll  = SCR_COPY_LO;
          end
        end else if (ch == CHAR_BELL) begin
          blink = BLINK_START;
        end else begin
          nxt_addr = rd_ptr + 8'd1;
          nxt      = text_mem[nxt_addr];
          queue_op(KIND_TILE, cur_col, cur_row, ch - cfg.font_offset, 5'd0, 6'd0);
          // no cursor ahead of a bell or past the visible width
          if (nxt != CHAR_BELL && cur_col < ROW_TILES - 1)
            queue_op(KIND_TILE, cur_col + 5'd1, cur_row, caret_tile, 5'd0, 6'd0);
          cur_col = cur_col + 5'd1;
        end
        rd_ptr = rd_ptr + 8'd1;
      end
    end
  endtask

  // phases one to three: the pending scroll, one command each
  task automatic scroll_out();
    logic [4:0] lm1;
    logic [4:0] half;
    lm1  = cfg.line_count - 5'd1;
    half = lm1 >> 1;
    case (scroll)
      SCR_COPY_LO: begin
        queue_op(KIND_COPY, 5'd0, cfg.first_row, 8'd0, cfg.first_row + 5'd1, {1'b0, half});
        scroll = SCR_COPY_HI;
      end
      SCR_COPY_HI: begin
        queue_op(KIND_COPY, 5'd0, cfg.first_row + half, 8'd0, cfg.first_row + half + 5'd1,
                 {1'b0, lm1 - half});
        scroll = SCR_FILL;
      end
      SCR_FILL: begin
        queue_op(KIND_FILL, 5'd0, cfg.first_row + lm1, CHAR_SPACE - cfg.font_offset, 5'd0,
                 6'(ROW_TILES));
        scroll = SCR_DONE;
      end
      default: ;
    endcase
  endtask

  task automatic console_tick();
    res_t op;
    tick_ops = 0;
    if (phase == 2'd0)
      type_step();
    else
      scroll_out();
    phase = phase + 2'd1;
    // mark the final command of this tick
    if (tick_ops != 0) begin
      op      = ops_due[ops_due.size() - 1];
      op.last = 1'b1;
      ops_due[ops_due.size() - 1] = op;
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  // compare outgoing transactions, then follow register writes and incoming items
  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      cfg.first_row   = FIRST_ROW_RST;
      cfg.line_count  = LINE_COUNT_RST;
      cfg.font_offset = FONT_OFFSET_RST;
      cfg.cursor_char = CURSOR_CHAR_RST;
      phase = '0;
      home_cursor();
      ops_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (ops_due.size() == 0) begin
          $error("result with nothing expected: kind %0d col %0d row %0d tile %0d",
                 m_tuser, m_tdata[4:0], m_tdata[9:5], m_tdata[17:10]);
          fails++;
        end else begin
          want = ops_due.pop_front();
          check_field("kind", want.kind, m_tuser);
          check_field("col", want.col, m_tdata[4:0]);
          check_field("row", want.row, m_tdata[9:5]);
          check_field("tile", want.tile, m_tdata[17:10]);
          check_field("src_row", want.src_row, m_tdata[22:18]);
          check_field("span", want.span, m_tdata[28:23]);
          check_field("last", want.last, m_tlast);
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_FIRST_ROW:   cfg.first_row   = pwdata[4:0];
          REG_LINE_COUNT:  cfg.line_count  = pwdata[4:0];
          REG_FONT_OFFSET: cfg.font_offset = pwdata[7:0];
          REG_CURSOR_CHAR: cfg.cursor_char = pwdata[7:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_LOAD)
          text_mem[s_tdata[7:0]] = s_tdata[15:8];
        else
          console_tick();
      end
    end
    ops_waiting <= ops_due.size();
  end

endmodule

// File: test/tb_typewriter_text_console.sv
`timescale 1ns / 100ps
// tb_typewriter_text_console: stimulus and verdict for the typewriter text console
// drives the text stream and register port; prediction is left to tcon_checker
// depends on tcon_pkg, tcon_checker and the console rtl

module tb_typewriter_text_console;
  import tcon_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 85;

  // receiver stall patterns
  localparam int RX_FREE  = 0;
  localparam int RX_LIGHT = 1;
  localparam int RX_HEAVY = 2;

  // text that walks every character class: cursor, no cursor before a bell,
  // a blink, newlines down to a scroll twice, and a restart
  localparam logic [71:0] DEMO_TEXT = {CHAR_END, 8'h80, CHAR_NEWLINE, CHAR_NEWLINE,
                                       CHAR_NEWLINE, 8'h20, CHAR_BELL, 8'hFF, 8'h01};

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;   // load_addr[7:0], load_byte[15:8]
  logic        s_tuser  = 1'b0; // cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // col[4:0], row[9:5], tile[17:10], src_row[22:18], span[28:23]
  logic [1:0]  m_tuser;         // kind
  logic        m_tlast;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  int   fails;
  int   ops_waiting;
  int   cycles      = 0;
  int   burst_left  = 0;
  int   line_left   = 0;
  int   end_pct     = 1;
  int   hold_left   = 0;
  int   mode_left   = 0;
  int   stall_mode  = RX_FREE;
  logic hold_req    = 1'b0;
  logic hold_taken  = 1'b0;

  typewriter_text_console uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  tcon_checker watcher (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fails       (fails),
    .ops_waiting (ops_waiting)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: one long hold-off on request, otherwise changing stall patterns
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left  <= $urandom_range(16, 96);
        stall_mode <= $urandom_range(RX_FREE, RX_HEAVY);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        RX_FREE:  m_tready <= 1'b1;
        RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
        default:  m_tready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  // line-structured text: mostly short lines, some long enough to wrap the column
  function automatic logic [7:0] text_byte();
    int         pick;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    c    = 8'($urandom);
    if (c == CHAR_END || c == CHAR_BELL || c == CHAR_NEWLINE)
      c = c + 8'd1;
    if (pick < end_pct) begin
      c = CHAR_END;
    end else if (pick < end_pct + 3) begin
      c = CHAR_BELL;
    end else if (line_left == 0) begin
      c = CHAR_NEWLINE;
      line_left = ($urandom_range(0, 4) == 0) ? $urandom_range(18, 36) : $urandom_range(0, 3);
    end else begin
      line_left--;
    end
    return c;
  endfunction

  // one transaction on the text stream, in bursts with random gaps
  task automatic send_item(input logic cmd, input logic [7:0] addr, input logic [7:0] chr);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {chr, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, 8'($urandom), 8'($urandom));
  endtask

  // stop sending and let every expected command and any silent work finish
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (ops_waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // register write: setup then access; the bus is released by the caller
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic set_console(input logic [4:0] fr, input logic [4:0] lc,
                             input logic [7:0] fo, input logic [7:0] cc);
    write_reg(REG_FIRST_ROW, {27'd0, fr});
    write_reg(REG_LINE_COUNT, {27'd0, lc});
    write_reg(REG_FONT_OFFSET, {24'd0, fo});
    write_reg(REG_CURSOR_CHAR, {24'd0, cc});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly ticks, with loads that keep rewriting the text under the reader
  task automatic run_phase(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 3) == 0)
        send_item(CMD_LOAD, 8'($urandom),
                  ($urandom_range(0, 4) == 0) ? 8'($urandom) : text_byte());
      else
        send_tick();
    end
  endtask

  initial begin : stimulus
    int         a;
    logic [4:0] fr;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // whole text store first, so no tick ever reads an unwritten entry
    for (a = 0; a < 256; a++)
      send_item(CMD_LOAD, 8'(a), text_byte());

    // directed: narrowest area at the top, zero offset and cursor code
    drain();
    set_console(5'd0, 5'd2, 8'd0, 8'd0);
    for (a = 0; a < 9; a++)
      send_item(CMD_LOAD, 8'(a), DEMO_TEXT[8*a +: 8]);
    repeat (80) send_tick();

    // widest area, top offsets; receiver holds off long enough to stall the input
    drain();
    set_console(5'd8, 5'd24, 8'd255, 8'd255);
    end_pct  = 0;
    hold_req <= 1'b1;
    run_phase(PHASE_ITEMS);

    // two lines at the very bottom
    drain();
    set_console(5'd30, 5'd2, 8'd32, 8'd129);
    end_pct = 1;
    run_phase(PHASE_ITEMS);

    // area running past row 31, rows wrap
    drain();
    set_console(5'd31, 5'd24, 8'($urandom), 8'($urandom));
    end_pct = 0;
    run_phase(PHASE_ITEMS);

    // random legal area
    drain();
    fr = $urandom_range(0, 22);
    set_console(fr, 5'($urandom_range(2, (32 - fr > 24) ? 24 : 32 - fr)),
                8'($urandom), 8'($urandom));
    end_pct = 1;
    run_phase(PHASE_ITEMS);

    // back to the reset settings
    drain();
    set_console(FIRST_ROW_RST, LINE_COUNT_RST, FONT_OFFSET_RST, CURSOR_CHAR_RST);
    end_pct = 2;
    run_phase(PHASE_ITEMS);

    drain();
    if (fails == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
src/tcon_pkg.sv
src/tcon_ram.sv
src/tcon_regs.sv
src/tcon_text.sv
src/tcon_engine.sv
src/tcon_outq.sv
src/typewriter_text_console.sv
test/tcon_checker.sv
test/tb_typewriter_text_console.sv
